// ===== hw/rtl/kif_pkg.sv =====
package kif_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 2048;
	localparam int unsigned REG_BITS = 12;
	localparam logic [REG_BITS-1:0] DIM_RESET = 12'd1200;
	localparam int unsigned RING_ROWS = 8;
	localparam int unsigned SLOT_BITS = $clog2(RING_ROWS);
	localparam int unsigned PIX_BITS = 32;
	localparam int unsigned WIN_COLS = 5;
	localparam int unsigned NUM_CH = 3;
	localparam int unsigned NUM_QUAD = 4;
	localparam int unsigned FIFO_DEPTH = 16;
	localparam int unsigned FIFO_PTR = $clog2(FIFO_DEPTH);
	// floor(x / 9) == (x * 7282) >> 16 for every x below 2296
	localparam logic [12:0] RECIP_NINE = 13'd7282;
	localparam int unsigned RECIP_SHIFT = 16;

	typedef enum logic {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// three-row sums of one window column, upper half and lower half
	typedef struct packed {
		logic [9:0]  sum_up;
		logic [9:0]  sum_dn;
		logic [17:0] sq_up;
		logic [17:0] sq_dn;
	} chan_part_t;

	typedef struct packed {
		chan_part_t [NUM_CH-1:0] ch;
		logic [7:0]              alpha;
	} win_col_t;

	typedef struct packed {
		logic valid;
		logic frame_end;
	} job_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       frame_end;
	} result_t;

	function automatic chan_part_t col_part(input logic [7:0] p0, input logic [7:0] p1,
		input logic [7:0] p2, input logic [7:0] p3, input logic [7:0] p4);
		chan_part_t r;
		r.sum_up = 10'(p0) + 10'(p1) + 10'(p2);
		r.sum_dn = 10'(p2) + 10'(p3) + 10'(p4);
		r.sq_up = 18'(p0) * 18'(p0) + 18'(p1) * 18'(p1) + 18'(p2) * 18'(p2);
		r.sq_dn = 18'(p2) * 18'(p2) + 18'(p3) * 18'(p3) + 18'(p4) * 18'(p4);
		return r;
	endfunction

endpackage

// ===== hw/rtl/kif_quad_select.sv =====
module kif_quad_select import kif_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  job_t     job,
	input  win_col_t win [WIN_COLS],
	output logic     push_valid,
	output result_t  push_data
);

	logic [11:0] sum_c1 [NUM_QUAD][NUM_CH];
	logic [19:0] sq_c1 [NUM_QUAD][NUM_CH];
	job_t        job_c1, job_c2, job_c3, job_c4;
	logic [7:0]  alpha_c1, alpha_c2, alpha_c3, alpha_c4;
	logic [11:0] sum_c2 [NUM_QUAD][NUM_CH];
	logic [23:0] var_c2 [NUM_QUAD][NUM_CH];
	logic [11:0] best_c3 [NUM_CH];
	logic [7:0]  mean_c4 [NUM_CH];

	// quadrant sums from column partials: down-right, down-left, up-left, up-right
	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_c1[0][c] <= 12'(win[2].ch[c].sum_dn) + 12'(win[3].ch[c].sum_dn)
				+ 12'(win[4].ch[c].sum_dn);
			sq_c1[0][c] <= 20'(win[2].ch[c].sq_dn) + 20'(win[3].ch[c].sq_dn)
				+ 20'(win[4].ch[c].sq_dn);
			sum_c1[1][c] <= 12'(win[0].ch[c].sum_dn) + 12'(win[1].ch[c].sum_dn)
				+ 12'(win[2].ch[c].sum_dn);
			sq_c1[1][c] <= 20'(win[0].ch[c].sq_dn) + 20'(win[1].ch[c].sq_dn)
				+ 20'(win[2].ch[c].sq_dn);
			sum_c1[2][c] <= 12'(win[0].ch[c].sum_up) + 12'(win[1].ch[c].sum_up)
				+ 12'(win[2].ch[c].sum_up);
			sq_c1[2][c] <= 20'(win[0].ch[c].sq_up) + 20'(win[1].ch[c].sq_up)
				+ 20'(win[2].ch[c].sq_up);
			sum_c1[3][c] <= 12'(win[2].ch[c].sum_up) + 12'(win[3].ch[c].sum_up)
				+ 12'(win[4].ch[c].sum_up);
			sq_c1[3][c] <= 20'(win[2].ch[c].sq_up) + 20'(win[3].ch[c].sq_up)
				+ 20'(win[4].ch[c].sq_up);
		end
		alpha_c1 <= win[2].alpha;
	end

	// scaled variance, 9 * sum of squares minus squared sum
	always_ff @(posedge clk) begin
		for (int q = 0; q < NUM_QUAD; q++) begin
			for (int c = 0; c < NUM_CH; c++) begin
				var_c2[q][c] <= (24'(sq_c1[q][c]) + {1'b0, sq_c1[q][c], 3'b000})
					- 24'(sum_c1[q][c]) * 24'(sum_c1[q][c]);
				sum_c2[q][c] <= sum_c1[q][c];
			end
		end
		alpha_c2 <= alpha_c1;
	end

	// least variance wins, earlier quadrant on ties
	always_ff @(posedge clk) begin
		logic [23:0] bv;
		logic [11:0] bs;
		for (int c = 0; c < NUM_CH; c++) begin
			bv = var_c2[0][c];
			bs = sum_c2[0][c];
			for (int q = 1; q < NUM_QUAD; q++) begin
				if (var_c2[q][c] < bv) begin
					bv = var_c2[q][c];
					bs = sum_c2[q][c];
				end
			end
			best_c3[c] <= bs;
		end
		alpha_c3 <= alpha_c2;
	end

	always_ff @(posedge clk) begin
		logic [24:0] prod;
		for (int c = 0; c < NUM_CH; c++) begin
			prod = 25'(best_c3[c]) * 25'(RECIP_NINE);
			mean_c4[c] <= prod[RECIP_SHIFT +: 8];
		end
		alpha_c4 <= alpha_c3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_c1 <= '0;
			job_c2 <= '0;
			job_c3 <= '0;
			job_c4 <= '0;
		end else begin
			job_c1 <= job;
			job_c2 <= job_c1;
			job_c3 <= job_c2;
			job_c4 <= job_c3;
		end
	end

	assign push_valid = job_c4.valid;
	assign push_data = '{red: mean_c4[0], green: mean_c4[1], blue: mean_c4[2],
		alpha: alpha_c4, frame_end: job_c4.frame_end};

endmodule

// ===== hw/rtl/kuwahara_image_filter_unit.sv =====
// kuwahara image filter, 5x5 window, per-channel least-variance quadrant mean
//
// channels: pixel requests enter on pix_valid/pix_ready with in_red, in_green,
// in_blue, in_alpha and flush; filtered pixels leave on res_valid/res_ready.
// image_width (address 0) and image_height (address 4) sit on the apb port and
// restart the frame when written; write them only while the block is idle.
// a result for pixel n becomes due once pixel n + 2*width + 2 has arrived, or
// at the frame end, so the last results of a frame are drained by flush
// requests (or by pixel requests after the frame is full, whose data is dropped).
// a due result passes the read request, line memory read, row pick, window, the
// quad_select stages and output fifo; a row opener first waits for its three reads.
// throughput: one request per cycle, except that a result that opens a row
// holds pix_ready low for its two further column reads, since its window needs
// three column reads of the column-organized line memory (one read port).
// reset clears the counters, pipeline valids and output queue; line memory
// contents are not cleared and every read hits a pixel already written.
// when the receiver stalls, results queue in a 16-entry output fifo and
// pix_ready drops once 16 results are outstanding.
module kuwahara_image_filter_unit import kif_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_alpha,
	input  logic        flush,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic        frame_end
);

	localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CW = AW + REG_BITS;
	localparam int unsigned WORD_BITS = RING_ROWS * PIX_BITS;

	// column read request into the line memory
	typedef struct packed {
		logic                valid;
		logic                fill;
		logic                done;
		logic                fe;
		logic [REG_BITS-1:0] row;
		logic [AW-1:0]       addr;
	} rd_req_t;

	function automatic logic [WW-1:0] clamp_w(input logic [REG_BITS-1:0] v);
		logic [WW-1:0] r;
		if (v == '0) begin
			r = WW'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			r = WW'(MAX_WIDTH);
		end else begin
			r = WW'(v);
		end
		return r;
	endfunction

	function automatic logic [REG_BITS-1:0] clamp_h(input logic [REG_BITS-1:0] v);
		return (v == '0) ? REG_BITS'(1) : v;
	endfunction

	// configuration registers and derived frame geometry
	logic [REG_BITS-1:0] width_q, height_q;
	logic [WW-1:0]       weff_q;
	logic [AW-1:0]       wm1_q;
	logic [REG_BITS-1:0] hm1_q;
	logic [CW-1:0]       total_q;
	logic [CW-1:0]       lag1_q;
	logic                cfg_we;
	logic [REG_BITS-1:0] new_w, new_h;
	logic [WW-1:0]       new_weff;
	logic [REG_BITS-1:0] new_heff;

	// input and emission counters
	logic [AW-1:0]       col_q, ec_q;
	logic [REG_BITS-1:0] row_q, er_q;
	logic [CW-1:0]       recv_q, emit_q, recv_n;
	logic                in_acc, is_pix, emit_ok, last_emit;

	// line memory, one word per column holding every ring row
	logic [WORD_BITS-1:0] line_mem [MAX_WIDTH];
	logic [WORD_BITS-1:0] rdata_s2;
	rd_req_t              rd_n, rd_s1, ctl_s2, ctl_s3;
	logic [1:0]           pend_q, pend_n;
	logic [PIX_BITS-1:0]  pix_s3 [WIN_COLS];
	logic [PIX_BITS-1:0]  pix_sel [WIN_COLS];

	// window of per-column partial sums
	win_col_t win_q [WIN_COLS];
	win_col_t new_col;
	job_t     job_s4;

	// output queue
	logic    push_valid;
	result_t push_data;
	result_t fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR-1:0] wr_q, rd_q;
	logic [FIFO_PTR:0]   cnt_q, outst_q;
	logic                out_acc;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		new_w = width_q;
		new_h = height_q;
		unique case (reg_idx_t'(paddr[2]))
			REG_IMAGE_WIDTH:  new_w = pwdata[REG_BITS-1:0];
			REG_IMAGE_HEIGHT: new_h = pwdata[REG_BITS-1:0];
			default:          new_w = width_q;
		endcase
		new_weff = clamp_w(new_w);
		new_heff = clamp_h(new_h);
	end

	// step decision, same order as a pixel write followed by a result check
	assign in_acc = pix_valid & pix_ready;
	assign out_acc = res_valid & res_ready;
	assign is_pix = !flush && (recv_q != total_q);
	assign recv_n = recv_q + CW'(is_pix);
	assign emit_ok = (emit_q < total_q)
		&& ((recv_n == total_q)
		|| ({1'b0, recv_n} >= ({1'b0, emit_q} + {1'b0, lag1_q})));
	assign last_emit = (({1'b0, emit_q} + (CW+1)'(1)) == {1'b0, total_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_RESET;
			height_q <= DIM_RESET;
			weff_q <= clamp_w(DIM_RESET);
			wm1_q <= AW'(clamp_w(DIM_RESET) - WW'(1));
			hm1_q <= clamp_h(DIM_RESET) - REG_BITS'(1);
			total_q <= CW'(clamp_w(DIM_RESET)) * CW'(clamp_h(DIM_RESET));
			lag1_q <= CW'({clamp_w(DIM_RESET), 1'b0}) + CW'(3);
			col_q <= '0;
			row_q <= '0;
			recv_q <= '0;
			emit_q <= '0;
			ec_q <= '0;
			er_q <= '0;
		end else if (cfg_we) begin
			width_q <= new_w;
			height_q <= new_h;
			weff_q <= new_weff;
			wm1_q <= AW'(new_weff - WW'(1));
			hm1_q <= new_heff - REG_BITS'(1);
			total_q <= CW'(new_weff) * CW'(new_heff);
			lag1_q <= CW'({new_weff, 1'b0}) + CW'(3);
			col_q <= '0;
			row_q <= '0;
			recv_q <= '0;
			emit_q <= '0;
			ec_q <= '0;
			er_q <= '0;
		end else if (in_acc) begin
			if (is_pix) begin
				recv_q <= recv_n;
				if ((WW'(col_q) + WW'(1)) == weff_q) begin
					col_q <= '0;
					row_q <= row_q + REG_BITS'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
			if (emit_ok) begin
				if (last_emit) begin
					// frame done, next pixel opens a new frame
					col_q <= '0;
					row_q <= '0;
					recv_q <= '0;
					emit_q <= '0;
					ec_q <= '0;
					er_q <= '0;
				end else begin
					emit_q <= emit_q + CW'(1);
					if ((WW'(ec_q) + WW'(1)) == weff_q) begin
						ec_q <= '0;
						er_q <= er_q + REG_BITS'(1);
					end else begin
						ec_q <= ec_q + AW'(1);
					end
				end
			end
		end
	end

	// column reads: one per result, three for the result that opens a row
	// (left edge replicated by filling the whole window with column 0)
	always_comb begin
		logic [AW:0] ahead;
		ahead = {1'b0, ec_q} + (AW+1)'(2);
		rd_n = rd_s1;
		rd_n.valid = 1'b0;
		pend_n = pend_q;
		if (in_acc && emit_ok) begin
			rd_n.valid = 1'b1;
			rd_n.row = er_q;
			rd_n.fe = last_emit;
			if (ec_q == '0) begin
				rd_n.addr = '0;
				rd_n.fill = 1'b1;
				rd_n.done = 1'b0;
				pend_n = 2'd2;
			end else begin
				rd_n.addr = (ahead > {1'b0, wm1_q}) ? wm1_q : ahead[AW-1:0];
				rd_n.fill = 1'b0;
				rd_n.done = 1'b1;
			end
		end else if (pend_q != 2'd0) begin
			rd_n.valid = 1'b1;
			rd_n.fill = 1'b0;
			rd_n.done = (pend_q == 2'd1);
			if (pend_q == 2'd2) begin
				rd_n.addr = (wm1_q < AW'(1)) ? wm1_q : AW'(1);
			end else begin
				rd_n.addr = (wm1_q < AW'(2)) ? wm1_q : AW'(2);
			end
			pend_n = pend_q - 2'd1;
		end
	end

	assign pix_ready = (pend_q == 2'd0) && (outst_q < (FIFO_PTR+1)'(FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			pend_q <= '0;
			job_s4 <= '0;
		end else begin
			rd_s1 <= rd_n;
			ctl_s2 <= rd_s1;
			ctl_s3 <= ctl_s2;
			pend_q <= pend_n;
			job_s4 <= '{valid: ctl_s3.valid & ctl_s3.done, frame_end: ctl_s3.fe};
		end
	end

	// pixel write lands before the read issued in the following cycle
	always_ff @(posedge clk) begin
		if (in_acc && is_pix && !cfg_we) begin
			line_mem[col_q][{row_q[SLOT_BITS-1:0], 5'b00000} +: PIX_BITS] <=
				{in_alpha, in_blue, in_green, in_red};
		end
		if (rd_s1.valid) begin
			rdata_s2 <= line_mem[rd_s1.addr];
		end
	end

	// pick rows r-2 .. r+2, replicated at the top and bottom edges
	always_comb begin
		logic signed [REG_BITS+1:0] rr;
		logic [SLOT_BITS-1:0]       slot;
		for (int k = 0; k < WIN_COLS; k++) begin
			rr = $signed({2'b00, ctl_s2.row}) + (REG_BITS+2)'(k - 2);
			if (rr < 0) begin
				slot = '0;
			end else if (rr > $signed({2'b00, hm1_q})) begin
				slot = hm1_q[SLOT_BITS-1:0];
			end else begin
				slot = rr[SLOT_BITS-1:0];
			end
			pix_sel[k] = rdata_s2[{slot, 5'b00000} +: PIX_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			for (int k = 0; k < WIN_COLS; k++) begin
				pix_s3[k] <= pix_sel[k];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			new_col.ch[c] = col_part(pix_s3[0][8*c +: 8], pix_s3[1][8*c +: 8],
				pix_s3[2][8*c +: 8], pix_s3[3][8*c +: 8], pix_s3[4][8*c +: 8]);
		end
		new_col.alpha = pix_s3[2][PIX_BITS-1 -: 8];
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.valid) begin
			for (int k = 0; k < WIN_COLS; k++) begin
				if (ctl_s3.fill || k == WIN_COLS - 1) begin
					win_q[k] <= new_col;
				end else begin
					win_q[k] <= win_q[k+1];
				end
			end
		end
	end

	kif_quad_select u_quad (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job_s4),
		.win        (win_q),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// output fifo; outstanding count covers results still in the pipeline
	always_ff @(posedge clk) begin
		if (push_valid) begin
			fifo_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			outst_q <= '0;
		end else begin
			if (push_valid) begin
				wr_q <= wr_q + FIFO_PTR'(1);
			end
			if (out_acc) begin
				rd_q <= rd_q + FIFO_PTR'(1);
			end
			cnt_q <= cnt_q + (FIFO_PTR+1)'(push_valid) - (FIFO_PTR+1)'(out_acc);
			outst_q <= outst_q + (FIFO_PTR+1)'(in_acc && emit_ok && !cfg_we)
				- (FIFO_PTR+1)'(out_acc);
		end
	end

	assign res_valid = (cnt_q != '0);
	assign out_red = fifo_q[rd_q].red;
	assign out_green = fifo_q[rd_q].green;
	assign out_blue = fifo_q[rd_q].blue;
	assign out_alpha = fifo_q[rd_q].alpha;
	assign frame_end = fifo_q[rd_q].frame_end;

endmodule

// ===== hw/rtl/kif_checker.sv =====
module kif_checker import kif_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        pready,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [7:0]  out_red,
	input logic [7:0]  out_green,
	input logic [7:0]  out_blue,
	input logic [7:0]  out_alpha,
	input logic        frame_end
);

	logic [31:0] open_q;
	logic        in_acc, out_acc;
	result_t     res_view;

	assign in_acc = pix_valid & pix_ready;
	assign out_acc = res_valid & res_ready;
	assign res_view = '{red: out_red, green: out_green, blue: out_blue,
		alpha: out_alpha, frame_end: frame_end};

	// requests taken minus results given
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 32'(in_acc) - 32'(out_acc);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_view))
		else $error("result dropped or changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("register access not completed at once");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> open_q != 32'd0)
		else $error("result given with no request behind it");

endmodule

bind kuwahara_image_filter_unit kif_checker u_kif_checker (.*);
